/* design/gsa_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the generational slot allocator
package gsa_pkg;

	localparam int SLOTS_DEF    = 1024;
	localparam int GEN_W        = 16;
	localparam int HANDLE_W     = 32;
	localparam int SLOT_FIELD_W = 16;
	localparam int COUNT_W      = 11;
	localparam int STATUS_W     = 3;
	localparam int KIND_W       = 2;
	localparam int QDEPTH       = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MARK   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SWEEP  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STALE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
		logic                range_err;
	} cmd_t;

endpackage

/* design/gsa_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module gsa_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/gsa_front.sv */
`timescale 1ns / 1ps
// front end: accepts items, checks the slot range and queues commands
module gsa_front #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsa_pkg::KIND_W-1:0]    kind,
	input  logic [gsa_pkg::HANDLE_W-1:0]  handle,
	output logic                          cmd_valid,
	output gsa_pkg::cmd_t                 cmd,
	input  logic                          cmd_pop
);
	import gsa_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam int RW = SLOT_FIELD_W + 1;

	cmd_t          q_mem [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	cmd_t          new_cmd;

	assign in_ready  = (count_q != CW'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem[rd_ptr_q];

	always_comb begin
		new_cmd.kind      = kind;
		new_cmd.handle    = handle;
		new_cmd.range_err = (RW'(handle[SLOT_FIELD_W-1:0]) >= RW'(SLOTS));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/gsa_back.sv */
`timescale 1ns / 1ps
// back end: executes commands against the free stack and the slot memory
module gsa_back #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  gsa_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsa_pkg::STATUS_W-1:0]  status,
	output logic [gsa_pkg::HANDLE_W-1:0]  new_handle,
	output logic                          found,
	output logic [gsa_pkg::COUNT_W-1:0]   freed_count
);
	import gsa_pkg::*;

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW  = $clog2(SLOTS + 1);
	localparam int DW1 = DW + 1;
	localparam int EW  = GEN_W + 1;

	localparam logic [SW-1:0] TOP_SLOT = SW'(SLOTS - 1);
	localparam logic [DW-1:0] FULL     = DW'(SLOTS);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ALLOC_RD = 3'd1;
	localparam logic [2:0] S_ALLOC_WR = 3'd2;
	localparam logic [2:0] S_CHECK    = 3'd3;
	localparam logic [2:0] S_SWEEP    = 3'd4;

	function automatic logic is_issued(input logic [SW-1:0] s, input logic [DW-1:0] mq);
		return (DW1'(s) + DW1'(mq)) < DW1'(SLOTS);
	endfunction

	// control state
	logic [2:0]    state_q, state_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [DW-1:0] minq_q, minq_d;
	logic          m0_q, m0_d;
	logic          issue_q, issue_d;
	logic          vld_s1, vld_d;
	logic          res_valid_q, res_valid_d;

	// payload state
	cmd_t               cmd_q, cmd_d;
	logic [SW-1:0]      slot_q, slot_d;
	logic               fresh_q, fresh_d;
	logic [SW-1:0]      idx_q, idx_d;
	logic [SW-1:0]      slot_s1, slot_s1_d;
	logic               last_s1, last_d;
	logic [COUNT_W-1:0] freed_q, freed_d;
	logic               ovf_q, ovf_d;

	logic [STATUS_W-1:0] status_q, status_d;
	logic [HANDLE_W-1:0] new_handle_q, new_handle_d;
	logic                found_q, found_d;
	logic [COUNT_W-1:0]  freed_count_q, freed_count_d;

	// memory ports
	logic          st_we, st_re;
	logic [SW-1:0] st_waddr, st_raddr, st_wdata, st_rdata;
	logic          sl_we, sl_re;
	logic [SW-1:0] sl_waddr, sl_raddr;
	logic [EW-1:0] sl_wdata, sl_rdata;

	logic                res_free;
	logic                produce;
	logic [SW-1:0]       pop_idx;
	logic [SW-1:0]       chk_slot;
	logic [GEN_W-1:0]    gen_new;
	logic [HANDLE_W-1:0] stored;
	logic                match;
	logic                marked;

	gsa_ram #(.W(SW), .DEPTH(SLOTS)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	gsa_ram #(.W(EW), .DEPTH(SLOTS)) u_slot (
		.clk   (clk),
		.we    (sl_we),
		.waddr (sl_waddr),
		.wdata (sl_wdata),
		.re    (sl_re),
		.raddr (sl_raddr),
		.rdata (sl_rdata)
	);

	assign res_free = !res_valid_q || out_ready;
	assign pop_idx  = SW'(depth_q - DW'(1));
	assign chk_slot = cmd_q.handle[SW-1:0];
	assign gen_new  = (fresh_q ? '0 : sl_rdata[GEN_W-1:0]) + GEN_W'(1);
	assign stored   = is_issued(chk_slot, minq_q) ?
		{sl_rdata[GEN_W-1:0], SLOT_FIELD_W'(chk_slot)} : '0;
	assign match    = (stored == cmd_q.handle);
	assign marked   = sl_rdata[GEN_W] &&
		(is_issued(slot_s1, minq_q) || ((slot_s1 == '0) && m0_q));

	always_comb begin
		cmd_pop       = 1'b0;
		st_we         = 1'b0;
		st_waddr      = SW'(depth_q);
		st_wdata      = slot_s1;
		st_re         = 1'b0;
		st_raddr      = pop_idx;
		sl_we         = 1'b0;
		sl_waddr      = slot_q;
		sl_wdata      = '0;
		sl_re         = 1'b0;
		sl_raddr      = slot_q;
		state_d       = state_q;
		depth_d       = depth_q;
		minq_d        = minq_q;
		m0_d          = m0_q;
		issue_d       = issue_q;
		vld_d         = 1'b0;
		cmd_d         = cmd_q;
		slot_d        = slot_q;
		fresh_d       = fresh_q;
		idx_d         = idx_q;
		slot_s1_d     = slot_s1;
		last_d        = last_s1;
		freed_d       = freed_q;
		ovf_d         = ovf_q;
		produce       = 1'b0;
		status_d      = ST_OK;
		new_handle_d  = '0;
		found_d       = 1'b0;
		freed_count_d = '0;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid && res_free) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					case (cmd.kind)
						KIND_ALLOC: begin
							if (depth_q == '0) begin
								produce  = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								depth_d = depth_q - DW'(1);
								if (DW'(pop_idx) < minq_q) begin
									// never written: entry still holds its reset slot
									fresh_d  = 1'b1;
									slot_d   = TOP_SLOT - pop_idx;
									sl_re    = 1'b1;
									sl_raddr = TOP_SLOT - pop_idx;
									minq_d   = DW'(pop_idx);
									state_d  = S_ALLOC_WR;
								end else begin
									fresh_d = 1'b0;
									st_re   = 1'b1;
									state_d = S_ALLOC_RD;
								end
							end
						end
						KIND_LOOKUP, KIND_MARK: begin
							if (cmd.range_err) begin
								produce  = 1'b1;
								status_d = ST_RANGE;
							end else begin
								sl_re    = 1'b1;
								sl_raddr = cmd.handle[SW-1:0];
								state_d  = S_CHECK;
							end
						end
						default: begin
							idx_d   = TOP_SLOT;
							issue_d = 1'b1;
							freed_d = '0;
							ovf_d   = 1'b0;
							state_d = S_SWEEP;
						end
					endcase
				end
			end
			S_ALLOC_RD: begin
				slot_d   = st_rdata;
				sl_re    = 1'b1;
				sl_raddr = st_rdata;
				state_d  = S_ALLOC_WR;
			end
			S_ALLOC_WR: begin
				sl_we    = 1'b1;
				sl_waddr = slot_q;
				sl_wdata = {1'b0, gen_new};
				if (slot_q == '0) begin
					m0_d = 1'b1;
				end
				produce      = 1'b1;
				status_d     = ST_OK;
				new_handle_d = {gen_new, SLOT_FIELD_W'(slot_q)};
				state_d      = S_IDLE;
			end
			S_CHECK: begin
				produce  = 1'b1;
				status_d = match ? ST_OK : ST_STALE;
				if (cmd_q.kind == KIND_LOOKUP) begin
					found_d = match;
				end else if (match) begin
					sl_we    = 1'b1;
					sl_waddr = chk_slot;
					sl_wdata = {1'b1, sl_rdata[GEN_W-1:0]};
					if (chk_slot == '0) begin
						m0_d = 1'b1;
					end
				end
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				// read walks down one slot a cycle, evaluation trails behind through slot_s1 and vld_s1
				if (issue_q) begin
					sl_re    = 1'b1;
					sl_raddr = idx_q;
					if (idx_q == '0) begin
						issue_d = 1'b0;
					end else begin
						idx_d = idx_q - SW'(1);
					end
				end
				vld_d     = issue_q;
				slot_s1_d = idx_q;
				last_d    = (idx_q == '0);
				if (vld_s1 && marked) begin
					sl_we    = 1'b1;
					sl_waddr = slot_s1;
					sl_wdata = {1'b0, sl_rdata[GEN_W-1:0]};
					if (depth_q < FULL) begin
						st_we    = 1'b1;
						st_waddr = SW'(depth_q);
						st_wdata = slot_s1;
						depth_d  = depth_q + DW'(1);
						if (freed_q != COUNT_MAX) begin
							freed_d = freed_q + COUNT_W'(1);
						end
					end else begin
						ovf_d = 1'b1;
					end
				end
				if (vld_s1 && last_s1) begin
					produce       = 1'b1;
					status_d      = ovf_d ? ST_OVERFLOW : ST_OK;
					freed_count_d = freed_d;
					vld_d         = 1'b0;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (produce) begin
			res_valid_d = 1'b1;
		end else if (out_ready) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= FULL;
			minq_q      <= FULL;
			m0_q        <= 1'b0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			minq_q      <= minq_d;
			m0_q        <= m0_d;
			issue_q     <= issue_d;
			vld_s1      <= vld_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		slot_q  <= slot_d;
		fresh_q <= fresh_d;
		idx_q   <= idx_d;
		slot_s1 <= slot_s1_d;
		last_s1 <= last_d;
		freed_q <= freed_d;
		ovf_q   <= ovf_d;
		if (produce) begin
			status_q      <= status_d;
			new_handle_q  <= new_handle_d;
			found_q       <= found_d;
			freed_count_q <= freed_count_d;
		end
	end

	assign out_valid   = res_valid_q;
	assign status      = status_q;
	assign new_handle  = new_handle_q;
	assign found       = found_q;
	assign freed_count = freed_count_q;

endmodule

/* design/generational_slot_allocator.sv */
`timescale 1ns / 1ps
// top level of the generational slot allocator
//
// Input channel (in_valid/in_ready) carries kind and handle; output channel
// (out_valid/out_ready) carries status, new_handle, found and freed_count,
// one result per input item, in order.
// Items pass through a two-entry command queue into an executor that owns
// the free-stack memory and the per-slot generation/mark memory, both with
// registered reads.
// Empty and range errors come straight from the idle state; lookup, mark
// and an allocate from untouched stack entries read the slot memory, an
// allocate of a recycled slot reads the stack and then the slot memory,
// and a sweep reads one slot per cycle from the highest down.
// The executor takes no new item until the read-modify-write of the last
// one through the slot memory is done and the result register is free.
// Reset: the stack holds every slot with slot 0 on top and all generations
// and marks read as zero; no clearing pass, the first item is taken at once.
// When the receiver stalls the result register holds; the queue keeps
// taking up to two more items before in_ready drops.
module generational_slot_allocator #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsa_pkg::KIND_W-1:0]    kind,
	input  logic [gsa_pkg::HANDLE_W-1:0]  handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsa_pkg::STATUS_W-1:0]  status,
	output logic [gsa_pkg::HANDLE_W-1:0]  new_handle,
	output logic                          found,
	output logic [gsa_pkg::COUNT_W-1:0]   freed_count
);
	import gsa_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	gsa_front #(.SLOTS(SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.handle    (handle),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gsa_back #(.SLOTS(SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.new_handle  (new_handle),
		.found       (found),
		.freed_count (freed_count)
	);

endmodule

/* design/gsa_checker.sv */
`timescale 1ns / 1ps
// port-level checker of the generational slot allocator and its bind
module gsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [gsa_pkg::KIND_W-1:0]    kind,
	input logic [gsa_pkg::HANDLE_W-1:0]  handle,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [gsa_pkg::STATUS_W-1:0]  status,
	input logic [gsa_pkg::HANDLE_W-1:0]  new_handle,
	input logic                          found,
	input logic [gsa_pkg::COUNT_W-1:0]   freed_count
);
	import gsa_pkg::*;

	// waiting input transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(handle))
		else $error("input changed while waiting");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(new_handle) && $stable(found) && $stable(freed_count))
		else $error("result changed while stalled");

	// a failed item never carries a handle
	a_err_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (new_handle == '0) && !found)
		else $error("handle or found on error result");

	// a lookup hit is a clean ok result
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (status == ST_OK) && (new_handle == '0) &&
		(freed_count == '0))
		else $error("found with other fields set");

	// only a sweep frees slots
	a_freed_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (freed_count != '0) |-> (new_handle == '0) &&
		((status == ST_OK) || (status == ST_OVERFLOW)))
		else $error("freed count on non-sweep result");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench for the generational slot allocator: directed and random commands checked against a scoreboard
module tb;
	import gsa_pkg::*;

	localparam int NSLOTS      = SLOTS_DEF;
	localparam int RANDOM_ITEMS = 1150;
	localparam int STALL_LIMIT = 10 * (NSLOTS + 16);
	localparam int HOLD_CYCLES = 250;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] new_handle;
		logic                found;
		logic [COUNT_W-1:0]  freed;
	} reply_t;

	class slot_tracker;
		bit [15:0]    stack_mem [NSLOTS];
		bit [GEN_W-1:0] gen_mem [NSLOTS];
		bit           mark_mem [NSLOTS];
		bit           issued_mem [NSLOTS];
		int           depth;
		int           issued_list [$];
		reply_t       replies_due [$];
		int           errors;
		int           replies_checked;
		int           kind_count [4];
		int           status_count [5];

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				stack_mem[i] = 16'(NSLOTS - 1 - i);
				gen_mem[i] = '0;
				mark_mem[i] = 1'b0;
				issued_mem[i] = 1'b0;
			end
			depth = NSLOTS;
			errors = 0;
			replies_checked = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function logic [HANDLE_W-1:0] stored_handle(int s);
			if (!issued_mem[s])
				return '0;
			return {gen_mem[s], 16'(s)};
		endfunction

		function void take_command(logic [KIND_W-1:0] k, logic [HANDLE_W-1:0] h);
			reply_t r;
			int s;
			r = '0;
			s = int'(h[15:0]);
			case (k)
				KIND_ALLOC: begin
					if (depth == 0) begin
						r.status = ST_EMPTY;
					end else begin
						depth--;
						s = int'(stack_mem[depth]);
						gen_mem[s] = gen_mem[s] + 1'b1;
						if (!issued_mem[s]) begin
							issued_mem[s] = 1'b1;
							issued_list.push_back(s);
						end
						mark_mem[s] = 1'b0;
						r.new_handle = stored_handle(s);
					end
				end
				KIND_LOOKUP, KIND_MARK: begin
					if (s >= NSLOTS)
						r.status = ST_RANGE;
					else if (stored_handle(s) != h)
						r.status = ST_STALE;
					else if (k == KIND_LOOKUP)
						r.found = 1'b1;
					else
						mark_mem[s] = 1'b1;
				end
				KIND_SWEEP: begin
					for (int i = NSLOTS - 1; i >= 0; i--) begin
						if (mark_mem[i]) begin
							mark_mem[i] = 1'b0;
							if (depth < NSLOTS) begin
								stack_mem[depth] = 16'(i);
								depth++;
								if (r.freed != COUNT_MAX)
									r.freed = r.freed + 1'b1;
							end else begin
								r.status = ST_OVERFLOW;
							end
						end
					end
				end
			endcase
			kind_count[k]++;
			status_count[r.status]++;
			replies_due.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d handle %h",
					$time, got.status, got.new_handle);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			replies_checked++;
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.new_handle !== want.new_handle) begin
				$display("%0t: new_handle expected %h actual %h", $time,
					want.new_handle, got.new_handle);
				errors++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.freed !== want.freed) begin
				$display("%0t: freed_count expected %0d actual %0d", $time, want.freed, got.freed);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [KIND_W-1:0]   kind;
	logic [HANDLE_W-1:0] handle;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] new_handle;
	logic                found;
	logic [COUNT_W-1:0]  freed_count;

	slot_tracker tracker = new();
	bit          steady;

	generational_slot_allocator #(.SLOTS(NSLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.handle(handle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.new_handle(new_handle),
		.found(found),
		.freed_count(freed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h);
		int gap;
		if (!steady && $urandom_range(0, 99) < 33) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		handle <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_command(k, h);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (tracker.replies_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		int s;
		logic [HANDLE_W-1:0] h;
		r = $urandom_range(0, 99);
		if (r < 10 || tracker.issued_list.size() == 0)
			return $urandom();
		if (r < 18)
			return {16'($urandom()), 16'($urandom_range(NSLOTS, 65535))};
		s = tracker.issued_list[$urandom_range(0, tracker.issued_list.size() - 1)];
		h = tracker.stored_handle(s);
		// stale generation
		if (r < 34)
			h = h ^ (32'h1 << (16 + $urandom_range(0, 15)));
		return h;
	endfunction

	task automatic send_random(input int w_alloc, input int w_lookup, input int w_mark);
		int r;
		logic [KIND_W-1:0] k;
		r = $urandom_range(0, 99);
		if (r < w_alloc)
			k = KIND_ALLOC;
		else if (r < w_alloc + w_lookup)
			k = KIND_LOOKUP;
		else if (r < w_alloc + w_lookup + w_mark)
			k = KIND_MARK;
		else
			k = KIND_SWEEP;
		if (k == KIND_LOOKUP || k == KIND_MARK)
			send_item(k, pick_handle());
		else
			send_item(k, $urandom());
	endtask

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_reply('{status, new_handle, found, freed_count});
			if (hold_left > 0) begin
				hold_left--;
			end else if (!held && tracker.replies_checked >= 200) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			out_ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 33);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n_random;
		int n_tail;
		n_random = 0;
		n_tail = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_ALLOC;
		handle <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unissued slot 0 matches handle zero
		send_item(KIND_LOOKUP, 32'h0000_0000);
		send_item(KIND_LOOKUP, 32'hFFFF_FFFF);
		send_item(KIND_MARK, {16'h0000, 16'(NSLOTS)});
		send_item(KIND_LOOKUP, 32'h0001_0000);
		send_item(KIND_MARK, 32'h0000_0000);
		// full stack: push dropped
		send_item(KIND_SWEEP, 32'hFFFF_FFFF);
		send_item(KIND_SWEEP, 32'h0000_0000);
		send_item(KIND_ALLOC, 32'hFFFF_FFFF);
		send_item(KIND_ALLOC, 32'h0000_0000);
		send_item(KIND_LOOKUP, 32'h0001_0000);
		send_item(KIND_LOOKUP, 32'h0002_0000);
		send_item(KIND_MARK, 32'h0002_0001);
		send_item(KIND_MARK, 32'h0001_0000);
		send_item(KIND_MARK, 32'h0001_0001);
		send_item(KIND_SWEEP, 32'h0000_0000);
		// released slot can be marked again
		send_item(KIND_MARK, 32'h0001_0000);
		send_item(KIND_SWEEP, 32'h0000_0000);
		send_item(KIND_ALLOC, 32'h0000_0000);
		send_item(KIND_LOOKUP, 32'h0001_0001);
		send_item(KIND_MARK, {16'h0001, 16'(NSLOTS - 1)});
		send_item(KIND_LOOKUP, 32'h0000_FFFF);
		send_item(KIND_MARK, 32'h0000_0000);
		send_item(KIND_LOOKUP, 32'hFFFF_0000);
		wait_quiet();

		// churn near a full stack
		steady = 1'b1;
		repeat (50) begin
			send_random(35, 25, 28);
			n_random++;
		end
		steady = 1'b0;
		repeat (50) begin
			send_random(35, 25, 28);
			n_random++;
		end

		// drain the free stack, then allocate from empty
		while (tracker.depth > 0) begin
			send_item(KIND_ALLOC, $urandom());
			n_random++;
		end
		repeat (8) begin
			send_item(KIND_ALLOC, $urandom());
			n_random++;
		end

		while (n_random < RANDOM_ITEMS || n_tail < 60) begin
			send_random(25, 25, 35);
			n_random++;
			n_tail++;
		end

		wait_quiet();
		repeat (NSLOTS + 8) @(posedge clk);
		$display("run covered %0d commands: %0d allocate, %0d lookup, %0d mark, %0d sweep",
			tracker.replies_checked, tracker.kind_count[KIND_ALLOC],
			tracker.kind_count[KIND_LOOKUP], tracker.kind_count[KIND_MARK],
			tracker.kind_count[KIND_SWEEP]);
		$display("outcomes: ok %0d, empty %0d, range %0d, stale %0d, overflow %0d",
			tracker.status_count[ST_OK], tracker.status_count[ST_EMPTY],
			tracker.status_count[ST_RANGE], tracker.status_count[ST_STALE],
			tracker.status_count[ST_OVERFLOW]);
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
design/gsa_pkg.sv
design/gsa_ram.sv
design/gsa_front.sv
design/gsa_back.sv
design/generational_slot_allocator.sv
design/gsa_checker.sv
tb/tb.sv
